/* sv/mcc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg: shared types for the mouse click classifier
// Word layouts, event codes, configuration register map and the cell scaler.
// ----------------------------------------------------------------------------
package mcc_pkg;

    localparam int RAW_W   = 12;
    localparam int CELL_W  = 9;
    localparam int TICK_W  = 32;
    localparam int BTN_W   = 3;
    localparam int SHIFT_W = 3;
    localparam int DCLK_W  = 8;
    localparam int CFG_W   = 8;

    localparam logic [CELL_W-1:0] CELL_MAX = '1;
    localparam logic [2:0]        RUN_MAX  = 3'd4;

    localparam logic              RST_ENABLE = 1'b1;
    localparam logic [SHIFT_W-1:0] RST_SHIFT = 3'd3;
    localparam logic [DCLK_W-1:0] RST_DCLICK = 8'd5;

    typedef enum logic [0:0] {
        OP_SAMPLE = 1'b0,
        OP_TAKE   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_LEFT    = 3'd1,
        EV_RIGHT   = 3'd2,
        EV_MIDDLE  = 3'd3,
        EV_DRAG    = 3'd4,
        EV_RELEASE = 3'd5
    } ev_t;

    typedef enum logic [1:0] {
        CFG_ENABLE = 2'd0,
        CFG_XSHIFT = 2'd1,
        CFG_YSHIFT = 2'd2,
        CFG_DCLICK = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic               operation;
        logic [BTN_W-1:0]   buttons;
        logic [RAW_W-1:0]   raw_x;
        logic [RAW_W-1:0]   raw_y;
        logic [TICK_W-1:0]  now_ticks;
    } in_word_t;

    typedef struct packed {
        logic               has_event;
        logic               left_button;
        logic               right_button;
        logic               middle_button;
        logic               multi_click;
        logic               dragging;
        logic               released;
        logic [CELL_W-1:0]  cell_x;
        logic [CELL_W-1:0]  cell_y;
    } out_word_t;

    typedef struct packed {
        logic               mouse_enable;
        logic [SHIFT_W-1:0] x_scale_shift;
        logic [SHIFT_W-1:0] y_scale_shift;
        logic [DCLK_W-1:0]  double_click_ticks;
    } cfg_t;

    // raw position to cell, saturating at the top of the grid
    function automatic logic [CELL_W-1:0] to_cell(logic [RAW_W-1:0] raw,
                                                  logic [SHIFT_W-1:0] sh);
        logic [RAW_W-1:0] v;
        v = raw >> sh;
        return (|v[RAW_W-1:CELL_W]) ? CELL_MAX : v[CELL_W-1:0];
    endfunction

endpackage

/* sv/mcc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_core: classifier state and event logic
// Holds the pending event and click history; updates them one word per step
// and forms the result word of a take.
// ----------------------------------------------------------------------------
module mcc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mcc_pkg::in_word_t item,
    input  mcc_pkg::cfg_t     cfg,
    output mcc_pkg::out_word_t result
);
    import mcc_pkg::*;

    ev_t                pend_reg,       pend_next;
    logic               multi_reg,      multi_next;
    logic [BTN_W-1:0]   prev_btn_reg,   prev_btn_next;
    logic [2:0]         count_reg,      count_next;
    logic [1:0]         click_btn_reg,  click_btn_next;
    logic [CELL_W-1:0]  click_col_reg,  click_col_next;
    logic [CELL_W-1:0]  click_row_reg,  click_row_next;
    logic [TICK_W-1:0]  click_time_reg, click_time_next;
    logic [CELL_W-1:0]  cur_col_reg,    cur_col_next;
    logic [CELL_W-1:0]  cur_row_reg,    cur_row_next;

    logic [CELL_W-1:0]  col;
    logic [CELL_W-1:0]  row;
    logic [TICK_W-1:0]  dt;
    logic               was_up;
    logic               is_up;
    logic               repeat_hit;
    ev_t                code;
    logic               do_sample;
    logic               do_take;

    assign col    = to_cell(item.raw_x, cfg.x_scale_shift);
    assign row    = to_cell(item.raw_y, cfg.y_scale_shift);
    assign dt     = item.now_ticks - click_time_reg;   // wraps
    assign was_up = (prev_btn_reg == '0);
    assign is_up  = (item.buttons == '0);

    always_comb
    begin
        priority if (item.buttons[0])
            code = EV_LEFT;
        else if (item.buttons[1])
            code = EV_RIGHT;
        else
            code = EV_MIDDLE;
    end

    assign repeat_hit = (click_btn_reg != 2'd0) && (code[1:0] == click_btn_reg) &&
                        (col == click_col_reg) && (row == click_row_reg) &&
                        (count_reg != RUN_MAX) &&
                        (dt < {{(TICK_W-DCLK_W){1'b0}}, cfg.double_click_ticks});

    assign do_sample = step && (item.operation == OP_SAMPLE) &&
                       cfg.mouse_enable && (pend_reg == EV_NONE);
    assign do_take   = step && (item.operation == OP_TAKE) &&
                       cfg.mouse_enable && (pend_reg != EV_NONE);

    always_comb
    begin
        pend_next       = pend_reg;
        multi_next      = multi_reg;
        prev_btn_next   = prev_btn_reg;
        count_next      = count_reg;
        click_btn_next  = click_btn_reg;
        click_col_next  = click_col_reg;
        click_row_next  = click_row_reg;
        click_time_next = click_time_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;

        if (do_sample)
        begin
            if (was_up != is_up)
            begin
                if (!was_up)
                begin
                    pend_next  = EV_RELEASE;
                    multi_next = 1'b0;
                end
                else
                begin
                    count_next      = repeat_hit ? count_reg + 3'd1 : 3'd1;
                    click_time_next = item.now_ticks;
                    click_btn_next  = code[1:0];
                    click_col_next  = col;
                    click_row_next  = row;
                    pend_next       = code;
                    multi_next      = repeat_hit;
                end
            end
            else if (!was_up && (col != cur_col_reg || row != cur_row_reg))
            begin
                pend_next  = EV_DRAG;
                multi_next = 1'b0;
            end
            prev_btn_next = item.buttons;
            cur_col_next  = col;
            cur_row_next  = row;
        end
        else if (do_take)
        begin
            pend_next  = EV_NONE;
            multi_next = 1'b0;
        end
    end

    always_comb
    begin
        result = '0;
        if (cfg.mouse_enable && pend_reg != EV_NONE)
        begin
            result.has_event     = 1'b1;
            result.left_button   = (pend_reg == EV_LEFT);
            result.right_button  = (pend_reg == EV_RIGHT);
            result.middle_button = (pend_reg == EV_MIDDLE);
            result.multi_click   = multi_reg;
            result.dragging      = (pend_reg == EV_DRAG);
            result.released      = (pend_reg == EV_RELEASE);
            result.cell_x        = (pend_reg == EV_DRAG) ? cur_col_reg : click_col_reg;
            result.cell_y        = (pend_reg == EV_DRAG) ? cur_row_reg : click_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= EV_NONE;
            multi_reg      <= 1'b0;
            prev_btn_reg   <= '0;
            count_reg      <= '0;
            click_btn_reg  <= '0;
            click_col_reg  <= '0;
            click_row_reg  <= '0;
            click_time_reg <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
        end
        else
        begin
            pend_reg       <= pend_next;
            multi_reg      <= multi_next;
            prev_btn_reg   <= prev_btn_next;
            count_reg      <= count_next;
            click_btn_reg  <= click_btn_next;
            click_col_reg  <= click_col_next;
            click_row_reg  <= click_row_next;
            click_time_reg <= click_time_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
        end
    end

`ifndef ASSERT_OFF
    // a press never lands without a button being recorded for it
    a_press_has_btn: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg == EV_LEFT || pend_reg == EV_RIGHT || pend_reg == EV_MIDDLE)
        |-> (click_btn_reg == pend_reg[1:0]))
        else $error("pending press disagrees with click button");

    // multi flag only ever rides on a press
    a_multi_press: assert property (@(posedge clk) disable iff (!rst_n)
        multi_reg |-> (pend_reg == EV_LEFT || pend_reg == EV_RIGHT ||
                       pend_reg == EV_MIDDLE))
        else $error("multi flag without a pending press");

    // run length stays within one to four once a press has been seen
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        (click_btn_reg != 2'd0) |-> (count_reg != 3'd0 && count_reg <= RUN_MAX))
        else $error("click run count out of range");
`endif

endmodule

/* sv/mouse_click_classifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_click_classifier: raw mouse samples to press, release and drag events
// Input register, classifier core, result register and configuration bank.
// ----------------------------------------------------------------------------
// One word is accepted per clock while in_stall is low. A word sits in the input register
// where the core classifies it; a take then loads the result register, from which
// its result word is offered until it is taken. Samples give no result.
// in_stall rises only when a take in the input register cannot move into a
// result register that is still full and stalled. Configuration writes take
// effect on the next clock and should only be made while the block is idle.
module mouse_click_classifier (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  mcc_pkg::in_word_t          in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output mcc_pkg::out_word_t         out_data,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [mcc_pkg::CFG_W-1:0]  cfg_wdata
);
    import mcc_pkg::*;

    in_word_t  item_reg;
    logic      item_valid_reg;
    out_word_t res_reg;
    logic      res_valid_reg;
    cfg_t      cfg_reg;
    out_word_t result;
    logic      item_is_take;
    logic      res_free;
    logic      advance;

    assign item_is_take = (item_reg.operation == OP_TAKE);
    assign res_free     = !res_valid_reg || !out_stall;
    assign advance      = item_valid_reg && (!item_is_take || res_free);
    assign in_stall     = item_valid_reg && !advance;
    assign out_valid    = res_valid_reg;
    assign out_data     = res_reg;

    mcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && item_is_take)
            res_valid_reg <= 1'b1;
        else if (!out_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_is_take)
            res_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mouse_enable       <= RST_ENABLE;
            cfg_reg.x_scale_shift      <= RST_SHIFT;
            cfg_reg.y_scale_shift      <= RST_SHIFT;
            cfg_reg.double_click_ticks <= RST_DCLICK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE: cfg_reg.mouse_enable       <= cfg_wdata[0];
                CFG_XSHIFT: cfg_reg.x_scale_shift      <= cfg_wdata[SHIFT_W-1:0];
                CFG_YSHIFT: cfg_reg.y_scale_shift      <= cfg_wdata[SHIFT_W-1:0];
                CFG_DCLICK: cfg_reg.double_click_ticks <= cfg_wdata[DCLK_W-1:0];
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a take leaving the input register must show up in the result register
    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_is_take) |=> res_valid_reg)
        else $error("take word lost on the way to the result register");

    // only a take can hold up the input side
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && item_is_take && res_valid_reg && out_stall))
        else $error("input stalled without a blocked take");

    // an event word names exactly one kind of event
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.has_event) |->
        $onehot({res_reg.left_button, res_reg.right_button, res_reg.middle_button,
                 res_reg.dragging, res_reg.released}))
        else $error("event word with no or several kinds");

    // an empty take is all zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.has_event) |-> (res_reg == '0))
        else $error("empty take carries stray fields");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the mouse click classifier
// Drives sample and take words with random gaps and output stalls, predicts
// every event word from its own copy of the classifier state, and compares
// each returned word field by field. A short directed table comes first
// (empty take, first press, multi-click run and its limit, drag with a mask
// change, release, button priority), then randomised click runs, drags, time
// jumps and noise over several register settings.
// ----------------------------------------------------------------------------
module tb;
    import mcc_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int N_DIRECTED  = 25;

    // has_event, left, right, middle, multi, dragging, released
    localparam logic [6:0] FLAGS_LEFT       = 7'b1100000;
    localparam logic [6:0] FLAGS_LEFT_MULTI = 7'b1100100;
    localparam logic [6:0] FLAGS_RIGHT      = 7'b1010000;
    localparam logic [6:0] FLAGS_DRAG       = 7'b1000010;
    localparam logic [6:0] FLAGS_RELEASE    = 7'b1000001;
    localparam out_word_t  NO_EVENT         = '0;

    typedef struct packed {
        logic      typed;
        out_word_t res;
        in_word_t  word;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_word_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_word_t  out_data;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;

    mouse_click_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // predictor copy of registers and classifier state
    logic                cfg_en   = RST_ENABLE;
    logic [SHIFT_W-1:0]  cfg_xsh  = RST_SHIFT;
    logic [SHIFT_W-1:0]  cfg_ysh  = RST_SHIFT;
    logic [DCLK_W-1:0]   cfg_dclk = RST_DCLICK;

    ev_t                 pend_ev    = EV_NONE;
    logic                pend_multi = 1'b0;
    logic [BTN_W-1:0]    held_btns  = '0;
    logic [2:0]          run_len    = '0;
    ev_t                 last_press = EV_NONE;
    logic [CELL_W-1:0]   press_col  = '0;
    logic [CELL_W-1:0]   press_row  = '0;
    logic [TICK_W-1:0]   press_tick = '0;
    logic [CELL_W-1:0]   cur_col    = '0;
    logic [CELL_W-1:0]   cur_row    = '0;

    out_word_t expected_events[$];

    int  fail_count      = 0;
    int  events_checked  = 0;
    int  words_sent      = 0;
    int  useful_words    = 0;
    int  takes_sent      = 0;
    bit  sender_rush     = 1'b0;
    bit  hold_off_req    = 1'b0;

    logic [TICK_W-1:0] tick_now = '0;
    logic [RAW_W-1:0]  home_x   = '0;
    logic [RAW_W-1:0]  home_y   = '0;

    function automatic logic [CELL_W-1:0] scale_to_cell(logic [RAW_W-1:0] raw,
                                                        logic [SHIFT_W-1:0] sh);
        logic [RAW_W-1:0] v;
        v = raw >> sh;
        if (v > RAW_W'(CELL_MAX))
            return CELL_MAX;
        return v[CELL_W-1:0];
    endfunction

    function automatic logic [6:0] flags_of(out_word_t w);
        return {w.has_event, w.left_button, w.right_button, w.middle_button,
                w.multi_click, w.dragging, w.released};
    endfunction

    // Returns 1 when the word gives a result; counted is 0 for ignored samples.
    function automatic bit predict_word(input in_word_t w, output out_word_t res,
                                        output bit counted);
        logic [CELL_W-1:0] col;
        logic [CELL_W-1:0] row;
        logic [TICK_W-1:0] since;
        ev_t               code;
        bit                was_up;
        bit                is_up;
        res     = '0;
        counted = 1'b0;
        if (w.operation == OP_TAKE)
        begin
            counted = 1'b1;
            if (cfg_en && pend_ev != EV_NONE)
            begin
                res.has_event     = 1'b1;
                res.left_button   = (pend_ev == EV_LEFT);
                res.right_button  = (pend_ev == EV_RIGHT);
                res.middle_button = (pend_ev == EV_MIDDLE);
                res.multi_click   = pend_multi;
                res.dragging      = (pend_ev == EV_DRAG);
                res.released      = (pend_ev == EV_RELEASE);
                res.cell_x        = (pend_ev == EV_DRAG) ? cur_col : press_col;
                res.cell_y        = (pend_ev == EV_DRAG) ? cur_row : press_row;
                pend_ev    = EV_NONE;
                pend_multi = 1'b0;
            end
            return 1'b1;
        end
        if (!cfg_en || pend_ev != EV_NONE)
            return 1'b0;
        counted = 1'b1;
        col    = scale_to_cell(w.raw_x, cfg_xsh);
        row    = scale_to_cell(w.raw_y, cfg_ysh);
        was_up = (held_btns == '0);
        is_up  = (w.buttons == '0);
        if (was_up != is_up)
        begin
            if (!was_up)
            begin
                pend_ev    = EV_RELEASE;
                pend_multi = 1'b0;
            end
            else
            begin
                if (w.buttons[0])
                    code = EV_LEFT;
                else if (w.buttons[1])
                    code = EV_RIGHT;
                else
                    code = EV_MIDDLE;
                since = w.now_ticks - press_tick;
                if (last_press != EV_NONE && code == last_press && col == press_col &&
                    row == press_row && run_len != RUN_MAX &&
                    since < TICK_W'(cfg_dclk))
                    run_len = run_len + 3'd1;
                else
                    run_len = 3'd1;
                press_tick = w.now_ticks;
                last_press = code;
                press_col  = col;
                press_row  = row;
                pend_ev    = code;
                pend_multi = (run_len > 3'd1);
            end
        end
        else if (!was_up && (col != cur_col || row != cur_row))
        begin
            pend_ev    = EV_DRAG;
            pend_multi = 1'b0;
        end
        held_btns = w.buttons;
        cur_col   = col;
        cur_row   = row;
        return 1'b0;
    endfunction

    function automatic in_word_t sample_word(logic [2:0] btn, logic [11:0] x,
                                             logic [11:0] y, logic [31:0] t);
        in_word_t w;
        w.operation = OP_SAMPLE;
        w.buttons   = btn;
        w.raw_x     = x;
        w.raw_y     = y;
        w.now_ticks = t;
        return w;
    endfunction

    // the other fields of a take carry no meaning, so they are scrambled
    function automatic in_word_t take_word();
        in_word_t w;
        w.operation = OP_TAKE;
        w.buttons   = BTN_W'($urandom);
        w.raw_x     = RAW_W'($urandom);
        w.raw_y     = RAW_W'($urandom);
        w.now_ticks = $urandom;
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        int        gap;
        out_word_t res;
        bit        counted;
        gap = sender_rush ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (in_stall);
        if (predict_word(w, res, counted))
        begin
            expected_events.push_back(typed ? typed_res : res);
            takes_sent++;
        end
        words_sent++;
        if (counted)
            useful_words++;
    endtask

    task automatic sample_at(logic [2:0] btn, logic [11:0] x, logic [11:0] y);
        send_word(sample_word(btn, x, y, tick_now), 1'b0, NO_EVENT);
    endtask

    // one take in ten is skipped, so later samples meet a pending event
    task automatic maybe_take();
        if ($urandom_range(0, 9) != 0)
            send_word(take_word(), 1'b0, NO_EVENT);
    endtask

    // stop offering words and wait for every outstanding event word
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        unique case (idx)
            CFG_ENABLE: cfg_en   = val[0];
            CFG_XSHIFT: cfg_xsh  = val[SHIFT_W-1:0];
            CFG_YSHIFT: cfg_ysh  = val[SHIFT_W-1:0];
            CFG_DCLICK: cfg_dclk = val;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_settings(logic en, logic [2:0] xs, logic [2:0] ys,
                                    logic [7:0] dc);
        settle();
        write_reg(CFG_ENABLE, {7'd0, en});
        write_reg(CFG_XSHIFT, {5'd0, xs});
        write_reg(CFG_YSHIFT, {5'd0, ys});
        write_reg(CFG_DCLICK, dc);
    endtask

    // presses and releases mostly on one cell, spaced around the multi-click window
    task automatic click_run();
        logic [2:0]  btn;
        logic [11:0] x;
        logic [11:0] y;
        int          reps;
        btn  = 3'($urandom_range(1, 7));
        reps = $urandom_range(1, 6);
        repeat (reps)
        begin
            if ($urandom_range(0, 4) == 0)
                btn = 3'($urandom_range(1, 7));
            if ($urandom_range(0, 5) == 0)
                home_x = home_x ^ 12'h010;
            x = home_x ^ 12'($urandom_range(0, 7));
            y = home_y ^ 12'($urandom_range(0, 7));
            tick_now = tick_now + $urandom_range(0, cfg_dclk + 2);
            sample_at(btn, x, y);
            maybe_take();
            tick_now = tick_now + $urandom_range(0, 2);
            sample_at(3'b000, x, y);
            maybe_take();
        end
    endtask

    task automatic drag_run();
        logic [2:0]  btn;
        logic [11:0] x;
        logic [11:0] y;
        int          moves;
        btn   = 3'($urandom_range(1, 7));
        x     = home_x;
        y     = home_y;
        moves = $urandom_range(1, 5);
        tick_now = tick_now + $urandom_range(0, 20);
        sample_at(btn, x, y);
        maybe_take();
        repeat (moves)
        begin
            if ($urandom_range(0, 3) == 0)
                btn = 3'($urandom_range(1, 7));
            x = x + 12'($urandom_range(0, 40));
            y = y + 12'($urandom_range(0, 40));
            tick_now = tick_now + $urandom_range(0, 3);
            sample_at(btn, x, y);
            maybe_take();
        end
        sample_at(3'b000, x, y);
        maybe_take();
        home_x = x;
        home_y = y;
    endtask

    task automatic jump_time();
        case ($urandom_range(0, 2))
            0: tick_now = $urandom;
            1: tick_now = 32'hFFFF_FFFF - $urandom_range(0, 6);  // wrap soon
            default: ;
        endcase
        home_x = RAW_W'($urandom);
        home_y = RAW_W'($urandom);
    endtask

    task automatic noise_burst();
        in_word_t w;
        int       n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            w.operation = 1'($urandom_range(0, 1));
            w.buttons   = BTN_W'($urandom);
            w.raw_x     = RAW_W'($urandom);
            w.raw_y     = RAW_W'($urandom);
            w.now_ticks = $urandom_range(0, 1) ? $urandom : tick_now;
            send_word(w, 1'b0, NO_EVENT);
        end
    endtask

    task automatic run_random(input int target);
        int goal;
        int kind;
        goal = useful_words + target;
        while (useful_words < goal)
        begin
            sender_rush = ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 5)
                click_run();
            else if (kind < 7)
                drag_run();
            else if (kind == 7)
                jump_time();
            else
                noise_burst();
        end
        sender_rush = 1'b0;
    endtask

    // receiver: random hold-off per word, with quiet stretches and one long hold
    initial
    begin
        int n;
        int quiet;
        out_stall = 1'b0;
        quiet     = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                n = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            else if (quiet > 0)
            begin
                n = 0;
                quiet--;
            end
            else
            begin
                n = $urandom_range(0, 14);
                if ($urandom_range(0, 15) == 0)
                    quiet = $urandom_range(10, 30);
            end
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        out_word_t exp_w;
        bit        bad;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected event word %h", $realtime, out_data);
            end
            else
            begin
                exp_w = expected_events.pop_front();
                events_checked++;
                bad = (out_data.has_event     !== exp_w.has_event)     ||
                      (out_data.left_button   !== exp_w.left_button)   ||
                      (out_data.right_button  !== exp_w.right_button)  ||
                      (out_data.middle_button !== exp_w.middle_button) ||
                      (out_data.multi_click   !== exp_w.multi_click)   ||
                      (out_data.dragging      !== exp_w.dragging)      ||
                      (out_data.released      !== exp_w.released)      ||
                      (out_data.cell_x        !== exp_w.cell_x)        ||
                      (out_data.cell_y        !== exp_w.cell_y);
                if (bad)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: mismatch exp %b cell=%0d,%0d got %b cell=%0d,%0d",
                                 $realtime, flags_of(exp_w), exp_w.cell_x, exp_w.cell_y,
                                 flags_of(out_data), out_data.cell_x, out_data.cell_y);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        dir_row_t directed_rows [0:N_DIRECTED-1];
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ENABLE;
        cfg_wdata = '0;

        // reset settings: shift 3, window 5 ticks
        directed_rows[0]  = {1'b1, NO_EVENT, take_word()};               // empty take
        directed_rows[1]  = {1'b0, NO_EVENT, sample_word(3'b001, 12'd0, 12'd0, 100)};
        directed_rows[2]  = {1'b1, {FLAGS_LEFT, 9'd0, 9'd0}, take_word()}; // first press
        directed_rows[3]  = {1'b0, NO_EVENT, sample_word(3'b000, 12'd0, 12'd0, 101)};
        directed_rows[4]  = {1'b1, {FLAGS_RELEASE, 9'd0, 9'd0}, take_word()};
        directed_rows[5]  = {1'b0, NO_EVENT, sample_word(3'b001, 12'd7, 12'd7, 102)};
        directed_rows[6]  = {1'b1, {FLAGS_LEFT_MULTI, 9'd0, 9'd0}, take_word()};
        directed_rows[7]  = {1'b0, NO_EVENT, sample_word(3'b000, 12'd0, 12'd0, 103)};
        directed_rows[8]  = {1'b0, NO_EVENT, take_word()};
        directed_rows[9]  = {1'b0, NO_EVENT, sample_word(3'b001, 12'd3, 12'd5, 104)};
        directed_rows[10] = {1'b0, NO_EVENT, take_word()};
        directed_rows[11] = {1'b0, NO_EVENT, sample_word(3'b000, 12'd0, 12'd0, 105)};
        directed_rows[12] = {1'b0, NO_EVENT, take_word()};
        directed_rows[13] = {1'b0, NO_EVENT, sample_word(3'b001, 12'd1, 12'd2, 106)};
        directed_rows[14] = {1'b0, NO_EVENT, take_word()};
        directed_rows[15] = {1'b0, NO_EVENT, sample_word(3'b000, 12'd0, 12'd0, 107)};
        directed_rows[16] = {1'b0, NO_EVENT, take_word()};
        // fifth press inside the window starts a fresh run
        directed_rows[17] = {1'b0, NO_EVENT, sample_word(3'b001, 12'd0, 12'd0, 108)};
        directed_rows[18] = {1'b1, {FLAGS_LEFT, 9'd0, 9'd0}, take_word()};
        // mask change while held, cell moved to the far corner
        directed_rows[19] = {1'b0, NO_EVENT,
                             sample_word(3'b110, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF)};
        directed_rows[20] = {1'b1, {FLAGS_DRAG, 9'd511, 9'd511}, take_word()};
        directed_rows[21] = {1'b0, NO_EVENT, sample_word(3'b000, 12'hFFF, 12'hFFF, 0)};
        directed_rows[22] = {1'b1, {FLAGS_RELEASE, 9'd0, 9'd0}, take_word()};
        // right beats middle
        directed_rows[23] = {1'b0, NO_EVENT, sample_word(3'b110, 12'hFFF, 12'd0, 1)};
        directed_rows[24] = {1'b1, {FLAGS_RIGHT, 9'd511, 9'd0}, take_word()};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

        program_settings(1'b1, 3'd4, 3'd4, 8'd255);
        run_random(240);
        program_settings(1'b1, 3'd3, 3'd4, 8'd0);
        run_random(200);
        program_settings(1'b0, 3'd4, 3'd3, 8'd9);
        run_random(60);
        program_settings(1'b1, 3'd4, 3'd3, 8'd1);
        run_random(200);

        // long output hold-off while takes keep coming: fills the block
        program_settings(1'b1, 3'd3, 3'd3, 8'($urandom_range(2, 40)));
        hold_off_req = 1'b1;
        sender_rush  = 1'b1;
        repeat (24) send_word(take_word(), 1'b0, NO_EVENT);
        sender_rush  = 1'b0;
        run_random(200);

        program_settings(1'b1, 3'd4, 3'd4, 8'($urandom_range(0, 255)));
        run_random(240);
        program_settings(1'b1, 3'd3, 3'd3, RST_DCLICK);
        run_random(240);

        settle();
        repeat (10) @(posedge clk);

        $display("Ran %0d words (%0d classified or taken, %0d takes), %0d event words checked.",
                 words_sent, useful_words, takes_sent, events_checked);
        $display("Seven register settings incl. mouse disabled, windows 0 and 255, long hold-off.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
